// ----- hdl/tsdf_pkg.sv -----
package tsdf_pkg;

    localparam int DATA_W     = 12;
    localparam int JIT_W      = 26;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int PROD_W     = 2 * DATA_W;

    localparam int DEF_HISTORY_DEPTH = 6;
    localparam int DEF_PANEL_WIDTH   = 320;
    localparam int DEF_PANEL_HEIGHT  = 240;

    localparam logic [DATA_W-1:0] RST_PRESSURE_THR = 12'd100;
    localparam logic [JIT_W-1:0]  RST_JITTER_THR   = 26'd30;
    localparam logic [DATA_W-1:0] RST_RAW_MIN      = 12'd0;
    localparam logic [DATA_W-1:0] RST_RAW_MAX      = 12'd4095;
    localparam logic [MODE_W-1:0] RST_MODE         = 4'd1;

    // mode_flags bit positions
    localparam int MODE_CAL    = 0;
    localparam int MODE_FLIP_X = 1;
    localparam int MODE_FLIP_Y = 2;
    localparam int MODE_PIN    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_THR = 3'd0,
        REG_JITTER_THR   = 3'd1,
        REG_RAW_X_MIN    = 3'd2,
        REG_RAW_X_MAX    = 3'd3,
        REG_RAW_Y_MIN    = 3'd4,
        REG_RAW_Y_MAX    = 3'd5,
        REG_MODE         = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_DOWN = 2'd1,
        PH_MOVE = 2'd2,
        PH_LIFT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] pressure_threshold;
        logic [JIT_W-1:0]  jitter_threshold;
        logic [DATA_W-1:0] raw_x_min;
        logic [DATA_W-1:0] raw_x_max;
        logic [DATA_W-1:0] raw_y_min;
        logic [DATA_W-1:0] raw_y_max;
        logic [MODE_W-1:0] mode_flags;
    } cfg_t;

    typedef struct packed {
        logic              pen_up;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } sample_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_WAIT,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD_OLD,
        BK_RD_MID,
        BK_RD_NEW,
        BK_SQ,
        BK_JIT,
        BK_SUM,
        BK_DIV,
        BK_APPEND,
        BK_DONE
    } back_state_t;

endpackage

// ----- hdl/tsdf_divider.sv -----
module tsdf_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             take;

    // one quotient bit per cycle, restoring
    assign trial     = {rem_reg, quot_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign take      = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], take};
            rem_reg  <= take ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- hdl/tsdf_queue.sv -----
module tsdf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsdf_pkg::sample_t wdata,
    output logic              full,
    input  logic              pop,
    output tsdf_pkg::sample_t rdata,
    output logic              empty
);
    import tsdf_pkg::*;

    sample_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        do_push;
    logic        do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- hdl/tsdf_front.sv -----
module tsdf_front #(
    parameter int PANEL_WIDTH  = tsdf_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = tsdf_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsdf_pkg::cfg_t              cfg,
    input  logic                        push,
    output logic                        full,
    input  logic [tsdf_pkg::DATA_W-1:0] pressure,
    input  logic                        pen_up_pin,
    input  logic [tsdf_pkg::DATA_W-1:0] raw_x,
    input  logic [tsdf_pkg::DATA_W-1:0] raw_y,
    output logic                        q_push,
    output tsdf_pkg::sample_t           q_data,
    input  logic                        q_full
);
    import tsdf_pkg::*;

    localparam logic [DATA_W-1:0] PW  = DATA_W'(PANEL_WIDTH);
    localparam logic [DATA_W-1:0] PH  = DATA_W'(PANEL_HEIGHT);
    localparam logic [PROD_W-1:0] PW1 = PROD_W'(PANEL_WIDTH - 1);
    localparam logic [PROD_W-1:0] PH1 = PROD_W'(PANEL_HEIGHT - 1);

    front_state_t      state_reg, state_next;
    logic              pen_reg, pen_next;
    logic [DATA_W-1:0] rx_reg, rx_next;
    logic [DATA_W-1:0] ry_reg, ry_next;
    logic [DATA_W-1:0] vx_reg, vx_next;
    logic [DATA_W-1:0] vy_reg, vy_next;
    logic [PROD_W-1:0] numx_reg, numx_next;
    logic [PROD_W-1:0] numy_reg, numy_next;
    logic [DATA_W-1:0] spx_reg, spx_next;
    logic [DATA_W-1:0] spy_reg, spy_next;
    logic              clrx_reg, clrx_next;
    logic              clry_reg, clry_next;

    logic              div_start;
    logic              divx_done;
    logic              divy_done;
    logic [PROD_W-1:0] qx;
    logic [PROD_W-1:0] qy;

    logic [DATA_W:0]   dx, dy, sx, sy;
    logic [DATA_W-1:0] mdx, mdy, msx, msy;

    // the dividers load at the same edge that starts them
    tsdf_divider #(.NUM_W(PROD_W), .DEN_W(DATA_W)) u_divx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numx_next),
        .den   (spx_next),
        .done  (divx_done),
        .quot  (qx)
    );

    tsdf_divider #(.NUM_W(PROD_W), .DEN_W(DATA_W)) u_divy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numy_next),
        .den   (spy_next),
        .done  (divy_done),
        .quot  (qy)
    );

    // signed differences as 13-bit two's complement
    assign dx  = {1'b0, rx_reg} - {1'b0, cfg.raw_x_min};
    assign dy  = {1'b0, ry_reg} - {1'b0, cfg.raw_y_min};
    assign sx  = {1'b0, cfg.raw_x_max} - {1'b0, cfg.raw_x_min};
    assign sy  = {1'b0, cfg.raw_y_max} - {1'b0, cfg.raw_y_min};
    assign mdx = dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
    assign mdy = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
    assign msx = sx[DATA_W] ? DATA_W'(-sx) : sx[DATA_W-1:0];
    assign msy = sy[DATA_W] ? DATA_W'(-sy) : sy[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        pen_reg  <= pen_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        spx_reg  <= spx_next;
        spy_reg  <= spy_next;
        clrx_reg <= clrx_next;
        clry_reg <= clry_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pen_next   = pen_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        numx_next  = numx_reg;
        numy_next  = numy_reg;
        spx_next   = spx_reg;
        spy_next   = spy_reg;
        clrx_next  = clrx_reg;
        clry_next  = clry_reg;
        div_start  = 1'b0;
        q_push     = 1'b0;

        case (state_reg)
            FR_IDLE:
            begin
                if (push)
                begin
                    pen_next = cfg.mode_flags[MODE_PIN] ? pen_up_pin
                                                        : (pressure < cfg.pressure_threshold);
                    rx_next  = raw_x;
                    ry_next  = raw_y;
                    vx_next  = raw_x;
                    vy_next  = raw_y;
                    state_next = cfg.mode_flags[MODE_CAL] ? FR_MUL : FR_PUSH;
                end
            end
            FR_MUL:
            begin
                // zero span or opposite signs give zero after the clamp
                numx_next = PROD_W'(mdx * PW);
                numy_next = PROD_W'(mdy * PH);
                spx_next  = msx;
                spy_next  = msy;
                clrx_next = (msx == '0) || (dx[DATA_W] != sx[DATA_W]);
                clry_next = (msy == '0) || (dy[DATA_W] != sy[DATA_W]);
                div_start = 1'b1;
                state_next = FR_WAIT;
            end
            FR_WAIT:
            begin
                if (divx_done)
                begin
                    vx_next = clrx_reg ? '0 : (qx > PW1) ? PW1[DATA_W-1:0] : qx[DATA_W-1:0];
                    vy_next = clry_reg ? '0 : (qy > PH1) ? PH1[DATA_W-1:0] : qy[DATA_W-1:0];
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // flip saturates at zero
    always_comb
    begin
        q_data.pen_up = pen_reg;
        q_data.x = vx_reg;
        q_data.y = vy_reg;
        if (cfg.mode_flags[MODE_FLIP_X])
            q_data.x = (vx_reg > PW) ? '0 : (PW - vx_reg);
        if (cfg.mode_flags[MODE_FLIP_Y])
            q_data.y = (vy_reg > PH) ? '0 : (PH - vy_reg);
    end

    assign full = (state_reg != FR_IDLE) || divy_done;

endmodule

// ----- hdl/tsdf_back.sv -----
module tsdf_back #(
    parameter int HISTORY_DEPTH = tsdf_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tsdf_pkg::JIT_W-1:0]  jitter_threshold,
    input  logic                        q_empty,
    input  tsdf_pkg::sample_t           q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  phase,
    output logic                        position_valid,
    output logic [tsdf_pkg::DATA_W-1:0] x_out,
    output logic [tsdf_pkg::DATA_W-1:0] y_out
);
    import tsdf_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int SUM_W = DATA_W + $clog2(HISTORY_DEPTH);
    localparam int SQ_W  = PROD_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);

    logic [DATA_W-1:0] hx_reg [HISTORY_DEPTH];
    logic [DATA_W-1:0] hy_reg [HISTORY_DEPTH];

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        step_reg, step_next;
    sample_t           smp_reg, smp_next;
    logic              app_reg, app_next;
    logic              pv_reg, pv_next;
    logic [DATA_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [DATA_W-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [DATA_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [SQ_W-1:0]   dthis_reg, dthis_next, dprev_reg, dprev_next;
    logic [SUM_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [DATA_W-1:0] ax_reg, ax_next, ay_reg, ay_next;

    logic              res_valid_reg, res_valid_next;
    phase_t            res_phase_reg, res_phase_next;
    logic              res_pv_reg, res_pv_next;
    logic [DATA_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;

    logic [IDX_W-1:0]  rd_idx;
    logic [DATA_W-1:0] rd_x, rd_y;
    logic [CNT_W-1:0]  cm1, cm2, cm3;
    logic [IDX_W-1:0]  last_idx;
    logic              jit_wr;
    logic              app_wr;
    logic [DATA_W-1:0] sq_a, sq_b, sq_d;
    logic [PROD_W-1:0] sq;
    logic              div_start;
    logic              divx_done;
    logic              divy_done;
    logic [SUM_W-1:0]  qx, qy;
    phase_t            ph;

    assign cm1      = count_reg - CNT_W'(1);
    assign cm2      = count_reg - CNT_W'(2);
    assign cm3      = count_reg - CNT_W'(3);
    assign last_idx = (count_reg <= CNT_W'(2)) ? '0 : cm2[IDX_W-1:0];
    assign rd_x     = hx_reg[rd_idx];
    assign rd_y     = hy_reg[rd_idx];

    tsdf_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_divx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sx_next),
        .den   (cm1),
        .done  (divx_done),
        .quot  (qx)
    );

    tsdf_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_divy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sy_next),
        .den   (cm1),
        .done  (divy_done),
        .quot  (qy)
    );

    // squared distance terms, one per step
    always_comb
    begin
        case (step_reg)
            2'd0:    begin sq_a = nx_reg; sq_b = ox_reg; end
            2'd1:    begin sq_a = ny_reg; sq_b = oy_reg; end
            2'd2:    begin sq_a = mx_reg; sq_b = ox_reg; end
            default: begin sq_a = my_reg; sq_b = oy_reg; end
        endcase
        sq_d = (sq_a > sq_b) ? (sq_a - sq_b) : (sq_b - sq_a);
        sq   = sq_d * sq_d;
    end

    always_ff @(posedge clk)
    begin
        if (jit_wr)
        begin
            hx_reg[cm2[IDX_W-1:0]] <= ox_reg;
            hy_reg[cm2[IDX_W-1:0]] <= oy_reg;
        end
        else if (app_wr)
        begin
            if (count_reg >= DEPTH_C)
            begin
                for (int i = 1; i < HISTORY_DEPTH; i++)
                begin
                    hx_reg[i-1] <= hx_reg[i];
                    hy_reg[i-1] <= hy_reg[i];
                end
                hx_reg[HISTORY_DEPTH-1] <= smp_reg.x;
                hy_reg[HISTORY_DEPTH-1] <= smp_reg.y;
            end
            else
            begin
                hx_reg[count_reg[IDX_W-1:0]] <= smp_reg.x;
                hy_reg[count_reg[IDX_W-1:0]] <= smp_reg.y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            phase_reg     <= PH_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        smp_reg       <= smp_next;
        app_reg       <= app_next;
        pv_reg        <= pv_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        mx_reg        <= mx_next;
        my_reg        <= my_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        dthis_reg     <= dthis_next;
        dprev_reg     <= dprev_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        res_phase_reg <= res_phase_next;
        res_pv_reg    <= res_pv_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        smp_next       = smp_reg;
        app_next       = app_reg;
        pv_next        = pv_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        dthis_next     = dthis_reg;
        dprev_next     = dprev_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        res_valid_next = res_valid_reg && !pop;
        res_phase_next = res_phase_reg;
        res_pv_next    = res_pv_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        rd_idx         = idx_reg;
        jit_wr         = 1'b0;
        app_wr         = 1'b0;
        div_start      = 1'b0;
        q_pop          = 1'b0;
        ph             = phase_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    smp_next = q_data;
                    idx_next = '0;
                    sx_next  = '0;
                    sy_next  = '0;
                    ax_next  = '0;
                    ay_next  = '0;
                    pv_next  = 1'b0;
                    if (q_data.pen_up && phase_reg != PH_DOWN && phase_reg != PH_MOVE)
                    begin
                        // pen up outside a stroke: clear and report phase none with no position
                        phase_next = PH_NONE;
                        count_next = '0;
                        app_next   = 1'b0;
                        state_next = BK_DONE;
                    end
                    else
                    begin
                        ph = q_data.pen_up ? PH_LIFT : phase_reg;
                        if (count_reg != '0 && (ph == PH_NONE || ph == PH_DOWN))
                            ph = phase_t'(ph + 2'd1);
                        phase_next = ph;
                        app_next   = 1'b1;
                        pv_next    = (count_reg != '0);
                        if (count_reg == '0)
                            state_next = BK_APPEND;
                        else if (count_reg >= CNT_W'(3))
                            state_next = BK_RD_OLD;
                        else
                            state_next = BK_SUM;
                    end
                end
            end
            BK_RD_OLD:
            begin
                rd_idx     = cm3[IDX_W-1:0];
                ox_next    = rd_x;
                oy_next    = rd_y;
                state_next = BK_RD_MID;
            end
            BK_RD_MID:
            begin
                rd_idx     = cm2[IDX_W-1:0];
                mx_next    = rd_x;
                my_next    = rd_y;
                state_next = BK_RD_NEW;
            end
            BK_RD_NEW:
            begin
                rd_idx     = cm1[IDX_W-1:0];
                nx_next    = rd_x;
                ny_next    = rd_y;
                step_next  = 2'd0;
                state_next = BK_SQ;
            end
            BK_SQ:
            begin
                case (step_reg)
                    2'd0:    dthis_next = SQ_W'(sq);
                    2'd1:    dthis_next = dthis_reg + SQ_W'(sq);
                    2'd2:    dprev_next = SQ_W'(sq);
                    default: dprev_next = dprev_reg + SQ_W'(sq);
                endcase
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                    state_next = BK_JIT;
            end
            BK_JIT:
            begin
                // pull the middle entry back onto the oldest of the three
                jit_wr = ((JIT_W'(dprev_reg) > jitter_threshold) && (dthis_reg < dprev_reg))
                         || (JIT_W'(dprev_reg) < jitter_threshold);
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                rd_idx  = idx_reg;
                sx_next = sx_reg + SUM_W'(rd_x);
                sy_next = sy_reg + SUM_W'(rd_y);
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == last_idx)
                begin
                    if (count_reg > CNT_W'(2))
                    begin
                        div_start  = 1'b1;
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        ax_next    = sx_next[DATA_W-1:0];
                        ay_next    = sy_next[DATA_W-1:0];
                        state_next = BK_APPEND;
                    end
                end
            end
            BK_DIV:
            begin
                if (divx_done && divy_done)
                begin
                    ax_next    = qx[DATA_W-1:0];
                    ay_next    = qy[DATA_W-1:0];
                    state_next = BK_APPEND;
                end
            end
            BK_APPEND:
            begin
                app_wr = app_reg;
                if (count_reg < DEPTH_C)
                    count_next = count_reg + CNT_W'(1);
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next = 1'b1;
                    res_phase_next = phase_reg;
                    res_pv_next    = pv_reg;
                    res_x_next     = ax_reg;
                    res_y_next     = ay_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign empty          = !res_valid_reg;
    assign phase          = res_phase_reg;
    assign position_valid = res_pv_reg;
    assign x_out          = res_x_reg;
    assign y_out          = res_y_reg;

endmodule

// ----- hdl/touch_sample_dejitter_filter.sv -----
// Calibration adds the work of the front's two 24-step dividers, which run side by side.
// Once three entries are held the back adds history reads, squared distances, a sum walk
//   and the average divider.
// At the default depth with a full history the back sets the pace; the front overlaps with
//   it through a 2-deep queue, so it can take a new sample while the back works on an earlier
//   one.
// Reset (rst_n, async low): registers return to their reset values, phase to none,
//   history empty, the queue and the result empty. History storage itself is not cleared.
module touch_sample_dejitter_filter #(
    parameter int HISTORY_DEPTH = tsdf_pkg::DEF_HISTORY_DEPTH,
    parameter int PANEL_WIDTH   = tsdf_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT  = tsdf_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsdf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [tsdf_pkg::DATA_W-1:0]     pressure,
    input  logic                            pen_up_pin,
    input  logic [tsdf_pkg::DATA_W-1:0]     raw_x,
    input  logic [tsdf_pkg::DATA_W-1:0]     raw_y,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      phase,
    output logic                            position_valid,
    output logic [tsdf_pkg::DATA_W-1:0]     x_out,
    output logic [tsdf_pkg::DATA_W-1:0]     y_out
);
    import tsdf_pkg::*;

    cfg_t    cfg_reg;
    logic    fq_push;
    sample_t fq_wdata;
    logic    fq_full;
    logic    fq_pop;
    sample_t fq_rdata;
    logic    fq_empty;

    // Configuration registers, no read-back: written only while idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_threshold <= RST_PRESSURE_THR;
            cfg_reg.jitter_threshold   <= RST_JITTER_THR;
            cfg_reg.raw_x_min          <= RST_RAW_MIN;
            cfg_reg.raw_x_max          <= RST_RAW_MAX;
            cfg_reg.raw_y_min          <= RST_RAW_MIN;
            cfg_reg.raw_y_max          <= RST_RAW_MAX;
            cfg_reg.mode_flags         <= RST_MODE;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PRESSURE_THR: cfg_reg.pressure_threshold <= cfg_data[DATA_W-1:0];
                REG_JITTER_THR:   cfg_reg.jitter_threshold   <= cfg_data[JIT_W-1:0];
                REG_RAW_X_MIN:    cfg_reg.raw_x_min          <= cfg_data[DATA_W-1:0];
                REG_RAW_X_MAX:    cfg_reg.raw_x_max          <= cfg_data[DATA_W-1:0];
                REG_RAW_Y_MIN:    cfg_reg.raw_y_min          <= cfg_data[DATA_W-1:0];
                REG_RAW_Y_MAX:    cfg_reg.raw_y_max          <= cfg_data[DATA_W-1:0];
                REG_MODE:         cfg_reg.mode_flags         <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front: decide pen state, then calibrate, clamp and flip the new sample as the mode flags select.
    tsdf_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .pressure   (pressure),
        .pen_up_pin (pen_up_pin),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .q_push     (fq_push),
        .q_data     (fq_wdata),
        .q_full     (fq_full)
    );

    // Hold classified samples so the front can run ahead of the back.
    tsdf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_wdata),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty)
    );

    // Back: stroke phase, dejitter, average of older entries, history append.
    tsdf_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .jitter_threshold (cfg_reg.jitter_threshold),
        .q_empty          (fq_empty),
        .q_data           (fq_rdata),
        .q_pop            (fq_pop),
        .empty            (empty),
        .pop              (pop),
        .phase            (phase),
        .position_valid   (position_valid),
        .x_out            (x_out),
        .y_out            (y_out)
    );

    // The front is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front accepted back-to-back items");

    // A reported position always belongs to a stroke.
    a_valid_in_stroke: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && position_valid) |-> (phase != PH_NONE))
        else $error("position reported with phase none");

    // Phase none carries a zero position.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && phase == PH_NONE) |-> (x_out == '0 && y_out == '0 && !position_valid))
        else $error("phase none with nonzero position");

endmodule
